[design/memory_test_pattern_checker_assert.svh]
// Assertion macros for the memory test pattern checker's port checker.
`ifndef MEMORY_TEST_PATTERN_CHECKER_ASSERT_SVH
`define MEMORY_TEST_PATTERN_CHECKER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define MTPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define MTPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/mtpc_pkg.sv]
// Types and constants of the memory test pattern checker.
package mtpc_pkg;

    localparam int GROUP_BITS = 16;
    localparam int LFSR_BITS  = 24;
    localparam int WC_W       = 25;
    localparam int DATA_W     = 32;
    localparam int SEED_W     = 31;
    localparam int MUL_W      = 15;
    localparam int MODE_W     = 3;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MUL_W-1:0]     PM_MUL      = 15'd16807;
    localparam logic [SEED_W-1:0]    PM_MOD      = 31'h7FFF_FFFF;
    localparam logic [LFSR_BITS-1:0] LFSR_TAPS   = 24'h00_0087;
    localparam logic [WC_W-1:0]      ERR_MAX     = '1;
    localparam logic [DATA_W-1:0]    MASK_BYTE   = 32'h0000_00FF;
    localparam logic [DATA_W-1:0]    MASK_HALF   = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0]    MASK_WORD   = 32'hFFFF_FFFF;

    localparam logic [MODE_W-1:0]    RST_MODE    = 3'd0;
    localparam logic [DATA_W-1:0]    RST_BASE    = 32'h4000_0000;
    localparam logic [WC_W-1:0]      RST_COUNT   = 25'd1000000;
    localparam logic [LFSR_BITS-1:0] RST_LFSR    = 24'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESTART = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_CHECK   = 2'd2
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADDR32    = 3'd0,
        MODE_RAND32    = 3'd1,
        MODE_BYTECOUNT = 3'd2,
        MODE_RAND8     = 3'd3,
        MODE_RAND16    = 3'd4,
        MODE_SCATTER32 = 3'd5
    } t_test_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEST_MODE    = 2'd0,
        CFG_BASE_ADDRESS = 2'd1,
        CFG_WORD_COUNT   = 2'd2,
        CFG_LFSR_START   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [DATA_W-1:0] word_address;
        logic [DATA_W-1:0] pattern_data;
        logic              mismatch;
        logic              group_end;
        logic              group_had_error;
        logic [WC_W-1:0]   error_total;
        logic              pass_done;
    } t_result;

endpackage

[design/mtpc_if.sv]
// Channel interfaces of the memory test pattern checker: command, result, configuration.
interface mtpc_in_if;
    import mtpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] read_data;
    modport source (output valid, output cmd, output read_data, input ready);
    modport sink   (input valid, input cmd, input read_data, output ready);
endinterface

interface mtpc_out_if;
    import mtpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] word_address;
    logic [DATA_W-1:0] pattern_data;
    logic              mismatch;
    logic              group_end;
    logic              group_had_error;
    logic [WC_W-1:0]   error_total;
    logic              pass_done;
    modport source (output valid, output word_address, output pattern_data,
                    output mismatch, output group_end, output group_had_error,
                    output error_total, output pass_done, input ready);
    modport sink   (input valid, input word_address, input pattern_data,
                    input mismatch, input group_end, input group_had_error,
                    input error_total, input pass_done, output ready);
endinterface

interface mtpc_cfg_if;
    import mtpc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/memory_test_pattern_checker.sv]
// Memory test pattern engine: address/data generation and read-back checking.
//
// Each command beat on i_in yields exactly one result beat on o_out. A restart
// (cmd 0) clears the item index, loads the Park-Miller seed with 1 and the
// scatter LFSR with lfsr_start, and zeroes the error counts; its result is all
// zero. A generate (cmd 1) or check (cmd 2) beat produces the byte address and
// pattern of the current item for test_mode, advances the generator that mode
// uses, and bumps the index; a check also compares read_data (masked to the
// access width) with the pattern and counts a mismatch, saturating at 2^25-1.
// Once the index reaches word_count, generate and check beats change nothing
// and return pass_done with a zero address and pattern. Every item whose index
// has its low GROUP_BITS bits clear flags group_end and reports in
// group_had_error whether any mismatch hit since the previous group end.
// Throughput is one beat per cycle while i_in.ready is high; results are registered.
// The per-cycle limit is the seed update loop: one 31x15 multiply followed by
// an end-around add and compare against 2^31-1, feeding the seed register.
// A result register plus a one-entry skid register sit on the output, so a
// beat is still taken while a finished result waits; i_in.ready drops only
// when both are full. Configuration writes are always ready and take effect
// at once; write them only while the engine is idle.
module memory_test_pattern_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtpc_cfg_if.sink    i_cfg,
    mtpc_in_if.sink     i_in,
    mtpc_out_if.source  o_out
);
    import mtpc_pkg::*;

    // configuration registers
    logic [MODE_W-1:0]    r_test_mode;
    logic [DATA_W-1:0]    r_base_address;
    logic [WC_W-1:0]      r_word_count;
    logic [LFSR_BITS-1:0] r_lfsr_start;

    // pass state
    logic [WC_W-1:0]      r_index, n_index;
    logic [SEED_W-1:0]    r_seed, n_seed;
    logic [LFSR_BITS-1:0] r_lfsr, n_lfsr;
    logic [WC_W-1:0]      r_err_cnt, n_err_cnt;
    logic                 r_group_err, n_group_err;

    // output register and skid register
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic in_fire;
    logic cfg_fire;
    logic out_take;

    // Park-Miller step: seed*16807 mod (2^31-1), folding the high part back in
    logic [SEED_W+MUL_W-1:0] pm_prod;
    logic [SEED_W:0]         pm_sum;
    logic [SEED_W-1:0]       pm_next;

    // scatter LFSR step and the scattered word index (bit 24 forced on)
    logic [LFSR_BITS-1:0]    lfsr_next;
    logic [LFSR_BITS:0]      scatter;

    assign pm_prod   = r_seed * PM_MUL;
    assign pm_sum    = {1'b0, pm_prod[SEED_W-1:0]}
                       + {{(SEED_W+1-MUL_W){1'b0}}, pm_prod[SEED_W+MUL_W-1:SEED_W]};
    assign pm_next   = (pm_sum >= {1'b0, PM_MOD}) ? SEED_W'(pm_sum - {1'b0, PM_MOD})
                                                  : pm_sum[SEED_W-1:0];
    assign lfsr_next = {r_lfsr[LFSR_BITS-2:0], 1'b0} ^ (r_lfsr[LFSR_BITS-1] ? LFSR_TAPS : '0);
    assign scatter   = {1'b1, lfsr_next};

    assign cfg_fire    = i_cfg.valid & i_cfg.ready;
    assign in_fire     = i_in.valid & i_in.ready;
    assign out_take    = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_skid_valid;

    // Work out the result and the next pass state for the beat on i_in.
    always_comb begin
        logic              at_end;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] amask;
        logic              mis;
        n_result          = '0;
        n_result.error_total = r_err_cnt;
        n_index           = r_index;
        n_seed            = r_seed;
        n_lfsr            = r_lfsr;
        n_err_cnt         = r_err_cnt;
        n_group_err       = r_group_err;
        at_end            = (r_index >= r_word_count);
        addr              = '0;
        data              = '0;
        amask             = MASK_WORD;
        mis               = 1'b0;
        priority if (i_in.cmd == CMD_RESTART) begin
            n_index     = '0;
            n_seed      = SEED_W'(1);
            n_lfsr      = r_lfsr_start;
            n_err_cnt   = '0;
            n_group_err = 1'b0;
            n_result.error_total = '0;
        end else if ((i_in.cmd != CMD_WRITE && i_in.cmd != CMD_CHECK) || at_end) begin
            // finished pass or unused command: hold everything
            n_result.pass_done = at_end;
        end else begin
            unique case (t_test_mode'(r_test_mode))
                MODE_RAND32: begin
                    addr   = r_base_address + {5'd0, r_index, 2'b00};
                    data   = {1'b0, pm_next};
                    n_seed = pm_next;
                end
                MODE_BYTECOUNT: begin
                    addr  = r_base_address + {7'd0, r_index};
                    amask = MASK_BYTE;
                    data  = {7'd0, r_index} & MASK_BYTE;
                end
                MODE_RAND8: begin
                    addr   = r_base_address + {7'd0, r_index};
                    amask  = MASK_BYTE;
                    data   = {1'b0, pm_next} & MASK_BYTE;
                    n_seed = pm_next;
                end
                MODE_RAND16: begin
                    addr   = r_base_address + {6'd0, r_index, 1'b0};
                    amask  = MASK_HALF;
                    data   = {1'b0, pm_next} & MASK_HALF;
                    n_seed = pm_next;
                end
                MODE_SCATTER32: begin
                    addr   = r_base_address + {5'd0, scatter, 2'b00};
                    data   = {5'd0, scatter, 2'b00};
                    n_lfsr = lfsr_next;
                end
                default: begin
                    // address as data; unused modes fall here too
                    addr = r_base_address + {5'd0, r_index, 2'b00};
                    data = addr;
                end
            endcase
            mis = (i_in.cmd == CMD_CHECK) && ((i_in.read_data & amask) != data);
            if (mis && r_err_cnt != ERR_MAX) begin
                n_err_cnt = r_err_cnt + WC_W'(1);
            end
            if (r_index[GROUP_BITS-1:0] == '0) begin
                n_result.group_end       = 1'b1;
                n_result.group_had_error = r_group_err | mis;
                n_group_err              = 1'b0;
            end else begin
                n_group_err = r_group_err | mis;
            end
            n_index                  = r_index + WC_W'(1);
            n_result.word_address    = addr;
            n_result.pattern_data    = data;
            n_result.mismatch        = mis;
            n_result.error_total     = n_err_cnt;
        end
    end

    // Configuration registers: write on a config beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_mode    <= RST_MODE;
            r_base_address <= RST_BASE;
            r_word_count   <= RST_COUNT;
            r_lfsr_start   <= RST_LFSR;
        end else if (cfg_fire) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_TEST_MODE:    r_test_mode    <= i_cfg.data[MODE_W-1:0];
                CFG_BASE_ADDRESS: r_base_address <= i_cfg.data;
                CFG_WORD_COUNT:   r_word_count   <= i_cfg.data[WC_W-1:0];
                CFG_LFSR_START:   r_lfsr_start   <= i_cfg.data[LFSR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pass state: advance on every accepted command beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_seed      <= SEED_W'(1);
            r_lfsr      <= RST_LFSR;
            r_err_cnt   <= '0;
            r_group_err <= 1'b0;
        end else if (in_fire) begin
            r_index     <= n_index;
            r_seed      <= n_seed;
            r_lfsr      <= n_lfsr;
            r_err_cnt   <= n_err_cnt;
            r_group_err <= n_group_err;
        end
    end

    // Output side: load the result register when it frees up, else park the
    // new result in the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid  <= r_skid_valid | in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (!out_take && in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.word_address    = r_out.word_address;
    assign o_out.pattern_data    = r_out.pattern_data;
    assign o_out.mismatch        = r_out.mismatch;
    assign o_out.group_end       = r_out.group_end;
    assign o_out.group_had_error = r_out.group_had_error;
    assign o_out.error_total     = r_out.error_total;
    assign o_out.pass_done       = r_out.pass_done;

endmodule

[design/mtpc_port_checker.sv]
// Port-level checks for the memory test pattern checker, bound to its top level.
`include "memory_test_pattern_checker_assert.svh"

module mtpc_port_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [mtpc_pkg::DATA_W-1:0] i_word_address,
    input logic [mtpc_pkg::DATA_W-1:0] i_pattern_data,
    input logic                      i_mismatch,
    input logic                      i_group_end,
    input logic                      i_group_had_error,
    input logic [mtpc_pkg::WC_W-1:0] i_error_total,
    input logic                      i_pass_done
);
    import mtpc_pkg::*;

    // a stalled result stays offered
    `MTPC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // input stalls only behind a full output side
    `MTPC_ASSERT_NOW(a_stall_needs_out, !i_in_ready, i_out_valid, "input stalled with empty output")

    // a finished pass returns no word
    `MTPC_ASSERT_NOW(a_done_no_word, i_out_valid && i_pass_done, i_word_address == '0 && i_pattern_data == '0 && !i_mismatch && !i_group_end, "pass_done with word fields")

    // a counted mismatch leaves a nonzero total
    `MTPC_ASSERT_NOW(a_mis_counted, i_out_valid && i_mismatch, i_error_total != '0, "mismatch not counted")

    // group error is only reported at a group boundary
    `MTPC_ASSERT_NOW(a_gerr_at_end, i_out_valid && i_group_had_error, i_group_end, "group error off boundary")

endmodule

bind memory_test_pattern_checker mtpc_port_checker u_port_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_word_address    (o_out.word_address),
    .i_pattern_data    (o_out.pattern_data),
    .i_mismatch        (o_out.mismatch),
    .i_group_end       (o_out.group_end),
    .i_group_had_error (o_out.group_had_error),
    .i_error_total     (o_out.error_total),
    .i_pass_done       (o_out.pass_done)
);

[dv/tb.sv]
// Self-checking testbench for the memory test pattern checker.
`timescale 1ns / 100ps

module tb;
    import mtpc_pkg::*;

    // Codes that the package leaves unnamed: the spare command and a spare mode.
    localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE    = 3'd7;
    localparam logic [63:0]          PM_FACTOR     = 64'd16807;
    localparam logic [63:0]          PM_MODULUS    = 64'd2147483647;
    localparam logic [LFSR_BITS:0]   LFSR_FEEDBACK = 25'h100_0087;
    localparam logic [DATA_W-1:0]    SCATTER_BIT   = 32'h0100_0000;
    localparam int                   CYCLE_LIMIT   = 2_000_000;

    // How read_data of a beat is formed from the pattern the engine will expect.
    typedef enum {RD_MATCH, RD_FLIP, RD_RANDOM, RD_FIXED} t_read_kind;
    typedef enum {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} t_idle;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        t_read_kind        kind;
        logic [DATA_W-1:0] value;
    } t_test_cmd;

    logic clk = 1'b0;
    logic rst_n;

    mtpc_in_if  in_if();
    mtpc_out_if out_if();
    mtpc_cfg_if cfg_if();

    memory_test_pattern_checker u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 clk = ~clk;

    // Command beats waiting to be sent, and results owed by the engine, oldest first.
    t_test_cmd test_cmds[$];
    t_result   pending_patterns[$];

    // Register copies as the engine should hold them.
    logic [MODE_W-1:0]    cfg_mode;
    logic [DATA_W-1:0]    cfg_base;
    logic [WC_W-1:0]      cfg_word_count;
    logic [LFSR_BITS-1:0] cfg_lfsr_start;

    // Engine state as it should stand after every accepted beat.
    logic [WC_W-1:0]      pass_index;
    logic [SEED_W-1:0]    pm_seed;
    logic [LFSR_BITS-1:0] scatter_state;
    logic [WC_W-1:0]      error_tally;
    logic                 group_flag;

    t_idle       send_idle = IDLE_NONE;
    t_idle       recv_idle = IDLE_NONE;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned miscompares = 0;
    int unsigned cycle_count = 0;

    // Work out the result of one command beat. With commit low, only peek at
    // what the next beat would produce and leave the state alone.
    function automatic t_result advance_engine(input logic [CMD_W-1:0] cmd,
                                               input logic [DATA_W-1:0] rd,
                                               input bit commit);
        t_result              res;
        logic [DATA_W-1:0]    amask;
        logic [WC_W-1:0]      idx;
        logic [SEED_W-1:0]    seed;
        logic [LFSR_BITS-1:0] lfsr;
        logic [LFSR_BITS:0]   shifted;
        logic [DATA_W-1:0]    scat;
        logic [WC_W-1:0]      errs;
        logic                 gflag;
        logic [63:0]          prod;
        res   = '0;
        amask = MASK_WORD;
        idx   = pass_index;
        seed  = pm_seed;
        lfsr  = scatter_state;
        errs  = error_tally;
        gflag = group_flag;
        if (cmd == CMD_RESTART) begin
            // Restart: clear the pass, reload both generators; the result is all zero.
            if (commit) begin
                pass_index    = '0;
                pm_seed       = 31'd1;
                scatter_state = cfg_lfsr_start;
                error_tally   = '0;
                group_flag    = 1'b0;
            end
            return res;
        end
        res.error_total = errs;
        if (cmd == CMD_UNUSED || idx >= cfg_word_count) begin
            // Spare command or finished pass: change nothing.
            res.pass_done = (idx >= cfg_word_count);
            return res;
        end
        prod = {33'd0, seed} * PM_FACTOR;
        case (cfg_mode)
            MODE_RAND32: begin
                seed = SEED_W'(prod % PM_MODULUS);
                res.word_address = cfg_base + {5'd0, idx, 2'b00};
                res.pattern_data = {1'b0, seed};
            end
            MODE_BYTECOUNT: begin
                amask = MASK_BYTE;
                res.word_address = cfg_base + {7'd0, idx};
                res.pattern_data = {7'd0, idx} & amask;
            end
            MODE_RAND8: begin
                amask = MASK_BYTE;
                seed = SEED_W'(prod % PM_MODULUS);
                res.word_address = cfg_base + {7'd0, idx};
                res.pattern_data = {1'b0, seed} & amask;
            end
            MODE_RAND16: begin
                amask = MASK_HALF;
                seed = SEED_W'(prod % PM_MODULUS);
                res.word_address = cfg_base + {6'd0, idx, 1'b0};
                res.pattern_data = {1'b0, seed} & amask;
            end
            MODE_SCATTER32: begin
                // Step the LFSR once, then force bit 24 into the scattered word index.
                shifted = {lfsr, 1'b0};
                if (shifted[LFSR_BITS]) begin
                    shifted = shifted ^ LFSR_FEEDBACK;
                end
                lfsr = shifted[LFSR_BITS-1:0];
                scat = SCATTER_BIT | {8'd0, lfsr};
                res.word_address = cfg_base + {scat[29:0], 2'b00};
                res.pattern_data = {scat[29:0], 2'b00};
            end
            default: begin
                // Address-as-data; the spare modes land here as well.
                res.word_address = cfg_base + {5'd0, idx, 2'b00};
                res.pattern_data = res.word_address;
            end
        endcase
        if (cmd == CMD_CHECK && (rd & amask) != res.pattern_data) begin
            res.mismatch = 1'b1;
            gflag = 1'b1;
            if (errs != ERR_MAX) begin
                errs = errs + WC_W'(1);
            end
        end
        res.error_total = errs;
        if (idx[GROUP_BITS-1:0] == '0) begin
            // Group boundary: report and drop the group's error flag.
            res.group_end = 1'b1;
            res.group_had_error = gflag;
            gflag = 1'b0;
        end
        if (commit) begin
            pass_index    = idx + WC_W'(1);
            pm_seed       = seed;
            scatter_state = lfsr;
            error_tally   = errs;
            group_flag    = gflag;
        end
        return res;
    endfunction

    // Form read_data from the pattern the next beat will be checked against.
    function automatic logic [DATA_W-1:0] read_word(input t_test_cmd c);
        t_result           peek;
        logic [DATA_W-1:0] width_mask;
        peek = advance_engine(CMD_CHECK, '0, 1'b0);
        case (cfg_mode)
            MODE_BYTECOUNT, MODE_RAND8: width_mask = MASK_BYTE;
            MODE_RAND16:                width_mask = MASK_HALF;
            default:                    width_mask = MASK_WORD;
        endcase
        case (c.kind)
            // Match within the access width; scramble the bits above it.
            RD_MATCH:  return peek.pattern_data ^ ($urandom & ~width_mask);
            // Flip one bit inside the access width: a sure miscompare.
            RD_FLIP:   return peek.pattern_data ^
                              (32'h1 << $urandom_range(0, $countones(width_mask) - 1));
            RD_RANDOM: return $urandom;
            default:   return c.value;
        endcase
    endfunction

    function automatic int unsigned pick_gap(input t_idle level);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (level == IDLE_NONE || r < 55) begin
            return 0;
        end
        if (level == IDLE_LIGHT) begin
            return (r < 90) ? 0 : $urandom_range(1, 2);
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] cmd, input t_read_kind kind,
                            input logic [DATA_W-1:0] value);
        t_test_cmd c;
        c.cmd   = cmd;
        c.kind  = kind;
        c.value = value;
        test_cmds.push_back(c);
    endtask

    // Write one register and track it once the beat is taken.
    task automatic write_reg(input t_cfg_reg idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_TEST_MODE:    cfg_mode       = val[MODE_W-1:0];
            CFG_BASE_ADDRESS: cfg_base       = val;
            CFG_WORD_COUNT:   cfg_word_count = val[WC_W-1:0];
            default:          cfg_lfsr_start = val[LFSR_BITS-1:0];
        endcase
    endtask

    // Hold until every queued beat is sent and every result is back, then
    // let the pipeline settle.
    task automatic wait_drained();
        do @(negedge clk);
        while (test_cmds.size() != 0 || in_if.valid || pending_patterns.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic compare_field(input string fname, input logic [DATA_W-1:0] want_v,
                                 input logic [DATA_W-1:0] got_v);
        if (got_v !== want_v) begin
            miscompares++;
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want_v, got_v);
        end
    endtask

    // Command driver: predict each beat as it is taken, then load the next one
    // after its gap. Compute read_data only at load time, when the state is current.
    always @(posedge clk) begin : cmd_driver
        t_test_cmd c;
        if (!rst_n) begin
            in_if.valid    <= 1'b0;
            cfg_mode       = RST_MODE;
            cfg_base       = RST_BASE;
            cfg_word_count = RST_COUNT;
            cfg_lfsr_start = RST_LFSR;
            pass_index     = '0;
            pm_seed        = 31'd1;
            scatter_state  = 24'd1;
            error_tally    = '0;
            group_flag     = 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pending_patterns.push_back(advance_engine(in_if.cmd, in_if.read_data, 1'b1));
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (test_cmds.size() != 0) begin
                    c = test_cmds.pop_front();
                    in_if.cmd       <= c.cmd;
                    in_if.read_data <= read_word(c);
                    in_if.valid     <= 1'b1;
                    send_gap = pick_gap(send_idle);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: stall at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap(recv_idle);
        end
    end

    // Result monitor: compare every taken beat with the oldest expectation.
    always @(posedge clk) begin : result_monitor
        t_result got;
        t_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.word_address    = out_if.word_address;
            got.pattern_data    = out_if.pattern_data;
            got.mismatch        = out_if.mismatch;
            got.group_end       = out_if.group_end;
            got.group_had_error = out_if.group_had_error;
            got.error_total     = out_if.error_total;
            got.pass_done       = out_if.pass_done;
            if (pending_patterns.size() == 0) begin
                miscompares++;
                $display("%0t: result beat with nothing expected, actual 0x%0h",
                         $time, got);
            end else begin
                want = pending_patterns.pop_front();
                compare_field("word_address", want.word_address, got.word_address);
                compare_field("pattern_data", want.pattern_data, got.pattern_data);
                compare_field("mismatch", DATA_W'(want.mismatch), DATA_W'(got.mismatch));
                compare_field("group_end", DATA_W'(want.group_end), DATA_W'(got.group_end));
                compare_field("group_had_error", DATA_W'(want.group_had_error),
                              DATA_W'(got.group_had_error));
                compare_field("error_total", DATA_W'(want.error_total),
                              DATA_W'(got.error_total));
                compare_field("pass_done", DATA_W'(want.pass_done), DATA_W'(got.pass_done));
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int          k;
        int          batch;
        int          random_items;
        int unsigned r;
        logic [DATA_W-1:0] val;
        random_items = 0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_RESTART;
        in_if.read_data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_TEST_MODE;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: address-as-data from the default base. Hit read data
        // extremes, the spare command, and a miscompare on the first item of a pass.
        add_item(CMD_WRITE, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_MATCH, '0);
        add_item(CMD_CHECK, RD_FIXED, 32'h0000_0000);
        add_item(CMD_CHECK, RD_FIXED, 32'hFFFF_FFFF);
        add_item(CMD_UNUSED, RD_RANDOM, '0);
        add_item(CMD_RESTART, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_FLIP, '0);
        wait_drained();

        // Random bytes from the top address: wrap the address, run past a
        // three-word pass, and send the spare command once it is finished.
        write_reg(CFG_TEST_MODE, MODE_RAND8);
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_WORD_COUNT, 32'd3);
        @(negedge clk);
        add_item(CMD_RESTART, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_MATCH, '0);
        add_item(CMD_CHECK, RD_FLIP, '0);
        add_item(CMD_WRITE, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_MATCH, '0);
        add_item(CMD_UNUSED, RD_RANDOM, '0);
        wait_drained();

        // Scatter mode from the all-ones LFSR start at base zero.
        write_reg(CFG_TEST_MODE, MODE_SCATTER32);
        write_reg(CFG_BASE_ADDRESS, 32'h0);
        write_reg(CFG_LFSR_START, 32'hFF_FFFF);
        @(negedge clk);
        add_item(CMD_RESTART, RD_RANDOM, '0);
        add_item(CMD_WRITE, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_MATCH, '0);
        add_item(CMD_CHECK, RD_RANDOM, '0);
        wait_drained();

        // Zero LFSR start: every scattered word sits on bit 24 alone.
        write_reg(CFG_LFSR_START, 32'h0);
        write_reg(CFG_WORD_COUNT, 32'd4);
        @(negedge clk);
        add_item(CMD_RESTART, RD_RANDOM, '0);
        add_item(CMD_WRITE, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_MATCH, '0);
        wait_drained();

        // Empty pass in a spare mode: the pass is finished from the start.
        write_reg(CFG_TEST_MODE, MODE_SPARE);
        write_reg(CFG_WORD_COUNT, 32'd0);
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFC);
        @(negedge clk);
        add_item(CMD_RESTART, RD_RANDOM, '0);
        add_item(CMD_WRITE, RD_RANDOM, '0);
        wait_drained();

        // Word count of 2^24.
        write_reg(CFG_WORD_COUNT, 32'h0100_0000);
        @(negedge clk);
        add_item(CMD_RESTART, RD_RANDOM, '0);
        add_item(CMD_CHECK, RD_MATCH, '0);
        add_item(CMD_WRITE, RD_RANDOM, '0);
        wait_drained();

        // Random phases: new settings per phase, mostly restart-led passes of
        // well-formed checks with some miscompares, noise and stray commands.
        while (random_items < 1250) begin
            send_idle = t_idle'($urandom_range(0, 2));
            recv_idle = t_idle'($urandom_range(0, 2));
            r = $urandom_range(0, 99);
            val = (r < 6) ? MODE_SPARE : $urandom_range(MODE_ADDR32, MODE_SCATTER32);
            write_reg(CFG_TEST_MODE, val);
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h0;
                    1:       val = 32'hFFFF_FFFF;
                    2:       val = 32'hFFFF_FF00;
                    default: val = $urandom;
                endcase
                write_reg(CFG_BASE_ADDRESS, val);
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 4))
                    0:       val = 32'd1;
                    1:       val = $urandom_range(1, 8);
                    2, 3:    val = $urandom_range(20, 160);
                    default: val = 32'h0100_0000;
                endcase
                write_reg(CFG_WORD_COUNT, val);
            end
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0:       val = 32'd1;
                    1:       val = 32'hFF_FFFF;
                    default: val = $urandom_range(1, 24'hFF_FFFF);
                endcase
                write_reg(CFG_LFSR_START, val);
            end
            @(negedge clk);
            batch = $urandom_range(40, 140);
            if ($urandom_range(0, 99) < 85) begin
                add_item(CMD_RESTART, RD_RANDOM, '0);
            end
            for (k = 0; k < batch; k++) begin
                // Now and then, stop feeding halfway until the engine has caught up.
                if (k == batch / 2 && $urandom_range(0, 2) == 0) begin
                    wait_drained();
                end
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    add_item(CMD_RESTART, RD_RANDOM, '0);
                end else if (r < 6) begin
                    add_item(CMD_UNUSED, RD_RANDOM, '0);
                end else if (r < 34) begin
                    add_item(CMD_WRITE, RD_RANDOM, '0);
                end else if (r < 36) begin
                    add_item(CMD_CHECK, RD_FIXED,
                             ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF);
                end else if (r < 84) begin
                    add_item(CMD_CHECK, RD_MATCH, '0);
                end else if (r < 92) begin
                    add_item(CMD_CHECK, RD_FLIP, '0);
                end else begin
                    add_item(CMD_CHECK, RD_RANDOM, '0);
                end
            end
            random_items += batch;
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (miscompares == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
